/* hw/rtl/bcm_pkg.sv */
package bcm_pkg;

  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned ROW_N   = 4;
  localparam int unsigned COL_N   = 4;
  localparam int unsigned DRIVE_W = 8;

  localparam logic [DRIVE_W-1:0] DRIVE_BLANK = 8'h00;
  localparam logic [COL_N-1:0]   COL_NONE    = 4'h0;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [1:0]         col_x;
    logic [1:0]         row_y;
    logic [LEVEL_W-1:0] level;
  } item_t;

  typedef struct packed {
    logic               valid;
    item_t              item;
  } item_beat_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               frame_end;
    logic               sync;
  } result_t;

  typedef struct packed {
    logic               valid;
    result_t            res;
  } result_beat_t;

endpackage

/* hw/rtl/bcm_if.sv */
interface bcm_in_if;
  import bcm_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [1:0]         col_x;
  logic [1:0]         row_y;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, cmd, col_x, row_y, level, input ready);
  modport sink   (input valid, cmd, col_x, row_y, level, output ready);
endinterface

interface bcm_out_if;
  import bcm_pkg::*;

  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] drive;
  logic               frame_end;
  logic               sync;

  modport source (output valid, drive, frame_end, sync, input ready);
  modport sink   (input valid, drive, frame_end, sync, output ready);
endinterface

/* hw/rtl/bcm_in_stage.sv */
module bcm_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  bcm_in_if.sink             in_i,
  input  logic               advance_i,
  output bcm_pkg::item_beat_t beat_o
);
  import bcm_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign in_i.ready = !valid_q || advance_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{cmd: cmd_e'(in_i.cmd), col_x: in_i.col_x, row_y: in_i.row_y,
                  level: in_i.level};
    end
  end

  assign beat_o = '{valid: valid_q, item: item_q};

endmodule

/* hw/rtl/bcm_core.sv */
module bcm_core #(
  parameter int unsigned PLANES      = 12,
  parameter int unsigned FAST_PLANES = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bcm_pkg::item_beat_t   beat_i,
  input  logic                  out_free_i,
  output logic                  advance_o,
  output bcm_pkg::result_beat_t result_o
);
  import bcm_pkg::*;

  localparam int unsigned FAST_USED = (FAST_PLANES < PLANES) ? FAST_PLANES : PLANES;
  localparam bit          NO_SLOW   = (FAST_USED >= PLANES);
  localparam int unsigned PW        = $clog2(PLANES);
  localparam int unsigned DW        = PLANES;

  // One register per pixel, each holding that pixel's bit in every plane.
  logic [PLANES-1:0] pix_q [ROW_N][COL_N];

  logic [PW-1:0] plane_q, plane_d;
  logic [1:0]    row_q, row_d;
  logic [DW-1:0] dwell_q, dwell_d;
  logic          blank_q, blank_d;
  logic          sync_q, sync_d;

  logic                      tick;
  logic [PLANES+LEVEL_W-1:0] level_ext;
  logic [PLANES-1:0]         plane_bits;
  logic [COL_N-1:0]          cols;
  logic [DRIVE_W-1:0]        row_drive, drive;
  logic [DW-1:0]             need_m1;
  logic                      dwell_done, last_row, fast_plane, frame_end;

  assign advance_o = beat_i.valid && ((beat_i.item.cmd != CMD_TICK) || out_free_i);
  assign tick      = advance_o && (beat_i.item.cmd == CMD_TICK);

  // Level bits beyond the plane count drop out; planes beyond the level width read zero.
  assign level_ext  = (PLANES + LEVEL_W)'(beat_i.item.level);
  assign plane_bits = level_ext[PLANES-1:0];

  always_comb begin
    for (int c = 0; c < COL_N; c++) begin
      cols[c] = pix_q[row_q][c][plane_q];
    end
  end

  assign row_drive  = {(ROW_N)'(1) << row_q, cols};
  assign need_m1    = (DW'(1) << plane_q) - DW'(1);
  assign dwell_done = (dwell_q == need_m1);
  assign last_row   = (row_q == 2'(ROW_N - 1));
  assign fast_plane = ({1'b0, plane_q} < (PW + 1)'(FAST_USED));

  always_comb begin
    plane_d   = plane_q;
    row_d     = row_q;
    dwell_d   = dwell_q;
    blank_d   = blank_q;
    sync_d    = sync_q;
    frame_end = 1'b0;
    drive     = row_drive;
    if (fast_plane) begin
      if (blank_q) begin
        drive   = DRIVE_BLANK;
        blank_d = 1'b0;
        dwell_d = '0;
        if (last_row) begin
          row_d = '0;
          if (NO_SLOW) begin
            plane_d   = '0;
            sync_d    = ~sync_q;
            frame_end = 1'b1;
          end else begin
            plane_d = PW'(FAST_USED);
          end
        end else begin
          row_d   = row_q + 2'd1;
          plane_d = '0;
        end
      end else if (dwell_done) begin
        dwell_d = '0;
        if (({1'b0, plane_q} + (PW + 1)'(1)) >= (PW + 1)'(FAST_USED)) begin
          blank_d = 1'b1;
        end else begin
          plane_d = plane_q + PW'(1);
        end
      end else begin
        dwell_d = dwell_q + DW'(1);
      end
    end else begin
      blank_d = 1'b0;
      if (dwell_done) begin
        dwell_d = '0;
        if (last_row) begin
          row_d = '0;
          if (plane_q == PW'(PLANES - 1)) begin
            plane_d   = '0;
            sync_d    = ~sync_q;
            frame_end = 1'b1;
          end else begin
            plane_d = plane_q + PW'(1);
          end
        end else begin
          row_d = row_q + 2'd1;
        end
      end else begin
        dwell_d = dwell_q + DW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
      row_q   <= '0;
      dwell_q <= '0;
      blank_q <= 1'b0;
      sync_q  <= 1'b0;
    end else if (tick) begin
      plane_q <= plane_d;
      row_q   <= row_d;
      dwell_q <= dwell_d;
      blank_q <= blank_d;
      sync_q  <= sync_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_N; r++) begin
        for (int c = 0; c < COL_N; c++) begin
          pix_q[r][c] <= '0;
        end
      end
    end else if (advance_o) begin
      case (beat_i.item.cmd)
        CMD_WRITE: begin
          pix_q[beat_i.item.row_y][beat_i.item.col_x] <= plane_bits;
        end
        CMD_FILL: begin
          for (int r = 0; r < ROW_N; r++) begin
            for (int c = 0; c < COL_N; c++) begin
              pix_q[r][c] <= plane_bits;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result_o = '{valid: tick,
                      res: '{drive: drive, frame_end: frame_end, sync: sync_d}};

endmodule

/* hw/rtl/bcm_out_stage.sv */
module bcm_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bcm_pkg::result_beat_t result_i,
  output logic                  free_o,
  bcm_out_if.source             out_o
);
  import bcm_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (result_i.valid) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      res_q <= result_i.res;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.drive     = res_q.drive;
  assign out_o.frame_end = res_q.frame_end;
  assign out_o.sync      = res_q.sync;

endmodule

/* hw/rtl/bcm_led_matrix_scanner.sv */
// Binary code modulation scanner for a 4x4 LED matrix.
// The input channel carries commands: write one pixel's brightness, fill every
// pixel with one brightness, or advance the scan by one tick. Only a tick gives
// a beat on the output channel: the drive byte (row one-hot in bits 7..4,
// columns in bits 3..0, all zero on a blank tick), a frame end flag and the
// frame sync bit as it stands after the tick.
// A command is registered on acceptance and executed from the input register in
// the following cycle, or later for a tick while the output register is full; a
// tick's result is then loaded into the output register. One command is accepted
// per cycle when the output side keeps up; the scan and store update never hold
// the flow by themselves.
// Reset clears the pixel store, so the display starts dark, and restarts the
// scan at the first row of plane 0 with the sync bit low.
// When the receiver stalls, the result waits in the output register and one
// more command can sit in the input register; writes and fills still flow
// past a held result, and a tick waits until the output register frees.
module bcm_led_matrix_scanner #(
  parameter int unsigned PLANES      = 12,
  parameter int unsigned FAST_PLANES = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bcm_in_if.sink    in_i,
  bcm_out_if.source out_o
);
  import bcm_pkg::*;

  item_beat_t   beat;
  result_beat_t result;
  logic         advance;
  logic         out_free;

  bcm_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .beat_o    (beat)
  );

  bcm_core #(
    .PLANES      (PLANES),
    .FAST_PLANES (FAST_PLANES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat),
    .out_free_i (out_free),
    .advance_o  (advance),
    .result_o   (result)
  );

  bcm_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

endmodule

/* hw/rtl/bcm_checker.sv */
module bcm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] drive_i,
  input logic       frame_end_i,
  input logic       sync_i
);
  import bcm_pkg::*;

  logic out_beat;
  logic last_sync_q;

  assign out_beat = out_valid_i && out_ready_i;

  // Sync level carried by the most recent output beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sync_q <= 1'b0;
    end else if (out_beat) begin
      last_sync_q <= sync_i;
    end
  end

  a_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_i) &&
      $stable(frame_end_i) && $stable(sync_i))
    else $error("output beat changed while stalled");

  a_drive_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ($onehot(drive_i[7:4]) || drive_i == DRIVE_BLANK))
    else $error("drive byte has no single row and is not blank");

  a_sync_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> sync_i == (last_sync_q ^ frame_end_i))
    else $error("sync bit changed without a frame end");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid right after reset");

endmodule

bind bcm_led_matrix_scanner bcm_checker u_bcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .drive_i     (out_o.drive),
  .frame_end_i (out_o.frame_end),
  .sync_i      (out_o.sync)
);

/* sim/bcm_led_matrix_scanner_test.sv */
`timescale 1ns / 100ps

module bcm_led_matrix_scanner_test;
  import bcm_pkg::*;

  // The block runs with its default plane counts. A full frame is far longer
  // than the run, so the stimulus covers every fast plane, the blank ticks and
  // the first slow planes.
  localparam int unsigned SCAN_PLANES = 12;
  localparam int unsigned SCAN_FAST   = 6;
  localparam int unsigned FAST_USED   = (SCAN_FAST < SCAN_PLANES) ? SCAN_FAST : SCAN_PLANES;

  localparam logic [1:0]       CMD_UNUSED = 2'd3;
  localparam logic [COL_N-1:0] COL_ALL    = 4'hf;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni;

  bcm_in_if  in_bus ();
  bcm_out_if out_bus ();

  bcm_led_matrix_scanner #(
    .PLANES      (SCAN_PLANES),
    .FAST_PLANES (SCAN_FAST)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  item_t       cmd_queue[$];
  item_t       on_bus;
  result_t     drive_queue[$];
  result_t     want;
  int unsigned cycle_count;
  int unsigned error_count;

  // Shadow of the scanner state.
  logic [COL_N-1:0] plane_bits [SCAN_PLANES][ROW_N];
  int unsigned      plane_idx;
  int unsigned      row_idx;
  int unsigned      dwell;
  logic             blanking;
  logic             sync_bit;

  function automatic logic [DRIVE_W-1:0] row_byte();
    logic [DRIVE_W-1:0] b;
    b = '0;
    b[4 + row_idx] = 1'b1;
    b[COL_N-1:0] = plane_bits[plane_idx][row_idx];
    return b;
  endfunction

  function automatic void restart_frame();
    plane_idx = 0;
    row_idx   = 0;
    dwell     = 0;
    blanking  = 1'b0;
    sync_bit  = ~sync_bit;
  endfunction

  function automatic result_t scan_tick();
    result_t r;
    r.frame_end = 1'b0;
    if (plane_idx >= SCAN_PLANES) plane_idx = 0;
    if (plane_idx < FAST_USED) begin
      if (blanking) begin
        // Blank tick closing one row of the fast planes.
        blanking = 1'b0;
        dwell    = 0;
        r.drive  = DRIVE_BLANK;
        if (row_idx >= ROW_N - 1) begin
          row_idx = 0;
          if (FAST_USED >= SCAN_PLANES) begin
            restart_frame();
            r.frame_end = 1'b1;
          end else begin
            plane_idx = FAST_USED;
          end
        end else begin
          row_idx++;
          plane_idx = 0;
        end
      end else begin
        r.drive = row_byte();
        dwell++;
        if (dwell >= (1 << plane_idx)) begin
          dwell = 0;
          if (plane_idx + 1 >= FAST_USED) blanking = 1'b1;
          else plane_idx++;
        end
      end
    end else begin
      blanking = 1'b0;
      r.drive  = row_byte();
      dwell++;
      if (dwell >= (1 << plane_idx)) begin
        dwell = 0;
        if (row_idx >= ROW_N - 1) begin
          row_idx = 0;
          plane_idx++;
          if (plane_idx >= SCAN_PLANES) begin
            restart_frame();
            r.frame_end = 1'b1;
          end
        end else begin
          row_idx++;
        end
      end
    end
    r.sync = sync_bit;
    return r;
  endfunction

  function automatic void apply_command(item_t it);
    case (it.cmd)
      CMD_WRITE: begin
        for (int p = 0; p < SCAN_PLANES; p++) begin
          plane_bits[p][it.row_y][it.col_x] = it.level[p];
        end
      end
      CMD_FILL: begin
        for (int p = 0; p < SCAN_PLANES; p++) begin
          for (int r = 0; r < ROW_N; r++) begin
            plane_bits[p][r] = it.level[p] ? COL_ALL : COL_NONE;
          end
        end
      end
      CMD_TICK: drive_queue.push_back(scan_tick());
      default: ;
    endcase
  endfunction

  // Random back-pressure on both sides, switched off for one long stretch.
  function automatic logic hold_off();
    if (cycle_count >= 600 && cycle_count < 1100) return 1'b0;
    return $urandom_range(99) < 26;
  endfunction

  function automatic void add_item(logic [1:0] cmd, logic [1:0] x, logic [1:0] y,
                                   logic [LEVEL_W-1:0] level);
    item_t it;
    it.cmd   = cmd_e'(cmd);
    it.col_x = x;
    it.row_y = y;
    it.level = level;
    cmd_queue.push_back(it);
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(3))
      0: return '1;
      1: return '0;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.cmd   <= CMD_TICK;
      in_bus.col_x <= '0;
      in_bus.row_y <= '0;
      in_bus.level <= '0;
      cycle_count  <= 0;
      plane_idx    = 0;
      row_idx      = 0;
      dwell        = 0;
      blanking     = 1'b0;
      sync_bit     = 1'b0;
      for (int p = 0; p < SCAN_PLANES; p++) begin
        for (int r = 0; r < ROW_N; r++) plane_bits[p][r] = COL_NONE;
      end
    end else begin
      cycle_count <= cycle_count + 1;
      if (in_bus.valid && in_bus.ready) apply_command(on_bus);
      if (!in_bus.valid || in_bus.ready) begin
        if (cmd_queue.size() != 0 && !hold_off()) begin
          on_bus = cmd_queue.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.cmd   <= on_bus.cmd;
          in_bus.col_x <= on_bus.col_x;
          in_bus.row_y <= on_bus.row_y;
          in_bus.level <= on_bus.level;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (drive_queue.size() == 0) begin
          error_count++;
          $display("%0t: unexpected beat drive=%h frame_end=%b sync=%b", $time,
                   out_bus.drive, out_bus.frame_end, out_bus.sync);
        end else begin
          want = drive_queue.pop_front();
          if (out_bus.drive !== want.drive) begin
            error_count++;
            $display("%0t: drive expected %h actual %h", $time, want.drive, out_bus.drive);
          end
          if (out_bus.frame_end !== want.frame_end) begin
            error_count++;
            $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                     out_bus.frame_end);
          end
          if (out_bus.sync !== want.sync) begin
            error_count++;
            $display("%0t: sync expected %b actual %b", $time, want.sync, out_bus.sync);
          end
        end
      end
      out_bus.ready <= !hold_off();
    end
  end

  initial begin
    int unsigned counted;
    int unsigned pick;
    rst_ni = 1'b0;

    // Directed part: dark display after reset, fills and writes at the
    // extremes, split brightness patterns, and the unused command.
    repeat (3) add_item(CMD_TICK, 2'd0, 2'd0, 12'h000);
    add_item(CMD_FILL, 2'd0, 2'd0, 12'hfff);
    repeat (2) add_item(CMD_TICK, 2'd3, 2'd3, 12'hfff);
    add_item(CMD_WRITE, 2'd0, 2'd0, 12'h000);
    add_item(CMD_TICK, 2'd0, 2'd0, 12'h000);
    add_item(CMD_WRITE, 2'd3, 2'd3, 12'h055);
    add_item(CMD_WRITE, 2'd3, 2'd0, 12'hf80);
    add_item(CMD_UNUSED, 2'd3, 2'd3, 12'hfff);
    repeat (2) add_item(CMD_TICK, 2'd1, 2'd2, 12'h555);
    add_item(CMD_FILL, 2'd3, 2'd3, 12'h000);
    add_item(CMD_TICK, 2'd0, 2'd0, 12'h000);
    add_item(CMD_WRITE, 2'd1, 2'd2, 12'h03f);
    add_item(CMD_WRITE, 2'd2, 2'd1, 12'hfc0);
    add_item(CMD_FILL, 2'd0, 2'd0, 12'haaa);
    repeat (3) add_item(CMD_TICK, 2'd2, 2'd1, 12'h000);

    // Random part: mostly bursts of ticks so the scan runs deep into the
    // frame, with store updates and unused commands mixed in.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        repeat ($urandom_range(40, 1)) begin
          add_item(CMD_TICK, 2'($urandom), 2'($urandom), LEVEL_W'($urandom));
          counted++;
        end
      end else if (pick < 85) begin
        add_item(CMD_WRITE, 2'($urandom), 2'($urandom), pick_level());
        counted++;
      end else if (pick < 93) begin
        add_item(CMD_FILL, 2'($urandom), 2'($urandom), pick_level());
        counted++;
      end else begin
        add_item(CMD_UNUSED, 2'($urandom), 2'($urandom), LEVEL_W'($urandom));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (cmd_queue.size() != 0 || in_bus.valid || drive_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("[bcm_led_matrix_scanner] OK");
    end else begin
      $display("[bcm_led_matrix_scanner] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[bcm_led_matrix_scanner] ERROR");
    $finish;
  end

endmodule
